// File: rtl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg - shared types and constants for the attitude PID servo mixer
// Step codes for the lane sequence, register indexes and reset gains.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int STEP_W = 4;

    // Sequence of one tick inside every axis lane
    localparam logic [STEP_W-1:0] STEP_MUL_TAB  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_TCD  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_MAB  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_MCD  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ERR      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MUL_LP   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_INTEG    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SUM_P    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SUM_D    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SUM_I    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DONE     = 4'd10;

    // Configuration register indexes
    localparam logic [2:0] REG_ROLL_KP   = 3'd0;
    localparam logic [2:0] REG_ROLL_KI   = 3'd1;
    localparam logic [2:0] REG_PITCH_KP  = 3'd2;
    localparam logic [2:0] REG_PITCH_KI  = 3'd3;
    localparam logic [2:0] REG_YAW_KP    = 3'd4;
    localparam logic [2:0] REG_YAW_KI    = 3'd5;
    localparam logic [2:0] REG_SHARED_KD = 3'd6;
    localparam logic [2:0] REG_LOOP_PER  = 3'd7;

    localparam logic [15:0] KP_RESET = 16'd19200;
    localparam logic [15:0] KI_RESET = 16'd640;

    localparam logic signed [28:0] PULSE_CENTER = 29'sd1500;
    localparam logic signed [28:0] PULSE_LOW    = 29'sd1000;
    localparam logic signed [28:0] PULSE_HIGH   = 29'sd2000;

    typedef struct packed {
        logic              run;
        logic [STEP_W-1:0] step;
    } t_lane_ctl;

    typedef struct packed {
        logic [10:0]        pulse;
        logic signed [9:0]  applied;
    } t_lane_res;

endpackage

// File: rtl/attitude_pid_servo_mixer_unit.sv
// ----------------------------------------------------------------------------
// attitude_pid_servo_mixer_unit - quaternion attitude PID and servo mixer
// An input is accepted only while the unit is idle. Each item runs eleven
// lane steps (eight multiplies through each lane's single multiplier,
// error, sum and done) and holds at done until the output is free.
// A finished result waits in the output register while the next item runs.
// Synchronous active-low reset clears gains to defaults, integrators and
// previous errors to zero.
// ----------------------------------------------------------------------------
module attitude_pid_servo_mixer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // meas_w, meas_x, meas_y, meas_z, target_w, target_x, target_y, target_z
    input  logic [127:0]  i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // roll_pulse, pitch_pulse, yaw_pulse, roll_applied, pitch_applied,
    // yaw_applied, one zero pad bit
    output logic [63:0]   o_m_axis_tdata
);
    import aps_pkg::*;

    logic [15:0] r_roll_kp, r_roll_ki, r_pitch_kp, r_pitch_ki;
    logic [15:0] r_yaw_kp, r_yaw_ki, r_kd, r_lp;
    logic signed [15:0] r_mw, r_mx, r_my, r_mz, r_tw, r_tx, r_ty, r_tz;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [63:0]       r_out;
    logic              in_acc;
    logic              finish;
    t_lane_ctl         lane_ctl;
    t_lane_res         roll_res, pitch_res, yaw_res;

    assign o_s_axis_tready = !r_busy;
    assign in_acc  = i_s_axis_tvalid && !r_busy;
    assign finish  = r_busy && (r_step == STEP_DONE)
                     && (!r_out_valid || i_m_axis_tready);
    assign lane_ctl.run  = r_busy;
    assign lane_ctl.step = r_step;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_kp  <= KP_RESET;
            r_roll_ki  <= KI_RESET;
            r_pitch_kp <= KP_RESET;
            r_pitch_ki <= KI_RESET;
            r_yaw_kp   <= KP_RESET;
            r_yaw_ki   <= KI_RESET;
            r_kd       <= '0;
            r_lp       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROLL_KP:   r_roll_kp  <= i_cfg_wdata;
                REG_ROLL_KI:   r_roll_ki  <= i_cfg_wdata;
                REG_PITCH_KP:  r_pitch_kp <= i_cfg_wdata;
                REG_PITCH_KI:  r_pitch_ki <= i_cfg_wdata;
                REG_YAW_KP:    r_yaw_kp   <= i_cfg_wdata;
                REG_YAW_KI:    r_yaw_ki   <= i_cfg_wdata;
                REG_SHARED_KD: r_kd       <= i_cfg_wdata;
                REG_LOOP_PER:  r_lp       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mw <= i_s_axis_tdata[15:0];
            r_mx <= i_s_axis_tdata[31:16];
            r_my <= i_s_axis_tdata[47:32];
            r_mz <= i_s_axis_tdata[63:48];
            r_tw <= i_s_axis_tdata[79:64];
            r_tx <= i_s_axis_tdata[95:80];
            r_ty <= i_s_axis_tdata[111:96];
            r_tz <= i_s_axis_tdata[127:112];
        end
    end

    // Step sequencer; hold at the last step while the output register is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL_TAB;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_step <= STEP_MUL_TAB;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy && r_step != STEP_DONE) begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Merge the three lanes into one result transaction
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= {1'b0, yaw_res.applied, pitch_res.applied, roll_res.applied,
                      yaw_res.pulse, pitch_res.pulse, roll_res.pulse};
        end
    end

    // roll: xz - wy
    aps_lane u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_plus(1'b0),
        .i_ta(r_tx), .i_tb(r_tz), .i_tc(r_tw), .i_td(r_ty),
        .i_ma(r_mx), .i_mb(r_mz), .i_mc(r_mw), .i_md(r_my),
        .i_kp(r_roll_kp), .i_ki(r_roll_ki), .i_kd(r_kd), .i_lp(r_lp),
        .o_res(roll_res)
    );

    // pitch: yz + wx
    aps_lane u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_plus(1'b1),
        .i_ta(r_ty), .i_tb(r_tz), .i_tc(r_tw), .i_td(r_tx),
        .i_ma(r_my), .i_mb(r_mz), .i_mc(r_mw), .i_md(r_mx),
        .i_kp(r_pitch_kp), .i_ki(r_pitch_ki), .i_kd(r_kd), .i_lp(r_lp),
        .o_res(pitch_res)
    );

    // yaw: xy - wz
    aps_lane u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_plus(1'b0),
        .i_ta(r_tx), .i_tb(r_ty), .i_tc(r_tw), .i_td(r_tz),
        .i_ma(r_mx), .i_mb(r_my), .i_mc(r_mw), .i_md(r_mz),
        .i_kp(r_yaw_kp), .i_ki(r_yaw_ki), .i_kd(r_kd), .i_lp(r_lp),
        .o_res(yaw_res)
    );

endmodule

// File: rtl/aps_lane.sv
// ----------------------------------------------------------------------------
// aps_lane - one axis of the attitude PID
// Quaternion cross terms, error, saturating integrator and PID sum through
// one registered 33x17 multiplier, stepped by the shared sequencer.
// ----------------------------------------------------------------------------
module aps_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aps_pkg::t_lane_ctl   i_ctl,
    input  logic                 i_plus,
    input  logic signed [15:0]   i_ta,
    input  logic signed [15:0]   i_tb,
    input  logic signed [15:0]   i_tc,
    input  logic signed [15:0]   i_td,
    input  logic signed [15:0]   i_ma,
    input  logic signed [15:0]   i_mb,
    input  logic signed [15:0]   i_mc,
    input  logic signed [15:0]   i_md,
    input  logic [15:0]          i_kp,
    input  logic [15:0]          i_ki,
    input  logic [15:0]          i_kd,
    input  logic [15:0]          i_lp,
    output aps_pkg::t_lane_res   o_res
);
    import aps_pkg::*;

    logic signed [32:0] n_mul_a;
    logic signed [16:0] n_mul_b;
    logic signed [49:0] r_prod;
    logic signed [34:0] r_acc;
    logic signed [34:0] n_acc;
    logic signed [16:0] r_err;
    logic signed [16:0] r_prev;
    logic signed [31:0] r_integ;
    logic signed [49:0] r_sum;
    logic signed [34:0] acc_fin;
    logic signed [21:0] err_full;
    logic signed [16:0] err_sat;
    logic signed [17:0] err_diff;
    logic signed [19:0] integ_step;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [27:0] amount;
    logic signed [28:0] pulse_raw;
    logic signed [34:0] prod_lo;

    assign prod_lo  = r_prod[34:0];
    assign err_diff = 18'(r_err) - 18'(r_prev);

    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (i_ctl.step)
            STEP_MUL_TAB: begin n_mul_a = 33'(i_ta); n_mul_b = 17'(i_tb); end
            STEP_MUL_TCD: begin n_mul_a = 33'(i_tc); n_mul_b = 17'(i_td); end
            STEP_MUL_MAB: begin n_mul_a = 33'(i_ma); n_mul_b = 17'(i_mb); end
            STEP_MUL_MCD: begin n_mul_a = 33'(i_mc); n_mul_b = 17'(i_md); end
            STEP_MUL_LP:  begin n_mul_a = 33'(r_err); n_mul_b = {1'b0, i_lp}; end
            STEP_INTEG:   begin n_mul_a = 33'(r_err); n_mul_b = {1'b0, i_kp}; end
            STEP_SUM_P:   begin n_mul_a = 33'(err_diff); n_mul_b = {1'b0, i_kd}; end
            STEP_SUM_D:   begin n_mul_a = 33'(r_integ); n_mul_b = {1'b0, i_ki}; end
            default: ;
        endcase
    end

    // Cross-term accumulation: +p0, +/-p1, -p2, -/+p3
    always_comb begin
        n_acc = r_acc;
        case (i_ctl.step)
            STEP_MUL_TCD: n_acc = prod_lo;
            STEP_MUL_MAB: n_acc = i_plus ? r_acc + prod_lo : r_acc - prod_lo;
            STEP_MUL_MCD: n_acc = r_acc - prod_lo;
            default: ;
        endcase
    end

    always_comb begin
        acc_fin  = i_plus ? r_acc - prod_lo : r_acc + prod_lo;
        err_full = 22'(acc_fin >>> 13);
        if (err_full > 22'sd65535)        err_sat = 17'sd65535;
        else if (err_full < -22'sd65536)  err_sat = -17'sd65536;
        else                              err_sat = err_full[16:0];
    end

    always_comb begin
        integ_step = 20'(r_prod[33:0] >>> 14);
        integ_sum  = 33'(r_integ) + 33'(integ_step);
        if (integ_sum > 33'sd2147483647)       integ_sat = 32'sh7fffffff;
        else if (integ_sum < -33'sd2147483648) integ_sat = 32'sh80000000;
        else                                   integ_sat = integ_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
        if (i_ctl.run) begin
            r_acc <= n_acc;
            case (i_ctl.step)
                STEP_SUM_P: r_sum <= r_prod <<< 2;
                STEP_SUM_D: r_sum <= r_sum + (r_prod <<< 2);
                STEP_SUM_I: r_sum <= r_sum + r_prod;
                default: ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_prev  <= '0;
            r_integ <= '0;
        end else if (i_ctl.run) begin
            case (i_ctl.step)
                STEP_ERR:   r_err   <= err_sat;
                STEP_INTEG: r_integ <= integ_sat;
                STEP_SUM_P: r_prev  <= r_err;
                default: ;
            endcase
        end
    end

    // Truncate toward zero, then clamp the pulse
    always_comb begin
        if (r_sum < 0) amount = 28'((r_sum + 50'sd4194303) >>> 22);
        else           amount = 28'(r_sum >>> 22);
        pulse_raw = PULSE_CENTER + 29'(amount);
        if (pulse_raw <= PULSE_LOW) begin
            o_res.pulse   = 11'(PULSE_LOW);
            o_res.applied = '0;
        end else if (pulse_raw >= PULSE_HIGH) begin
            o_res.pulse   = 11'(PULSE_HIGH);
            o_res.applied = '0;
        end else begin
            o_res.pulse   = pulse_raw[10:0];
            o_res.applied = amount[9:0];
        end
    end

endmodule
